// ===== rtl/core/wrpp_pkg.sv =====
// shared types, widths and codes for the weighted random pick pool
`default_nettype none

package wrpp_pkg;

    // pool geometry
    localparam int POOL_DEPTH = 256;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    // field widths
    localparam int ITEM_W   = 16;
    localparam int WEIGHT_W = 16;
    localparam int DRAW_W   = 24;
    localparam int TOTAL_W  = 24;

    // running sum of all weights never overflows this width
    localparam int SUM_W = WEIGHT_W + IDX_W;
    localparam int ACC_W = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // request command codes
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PICK   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_ON_PICK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM_MODE   = 1'b1;

    typedef struct packed {
        logic remove_on_pick;
        logic uniform_mode;
    } t_cfg;

    // one pool entry as stored in memory
    typedef struct packed {
        logic [ITEM_W-1:0]   item;
        logic [WEIGHT_W-1:0] weight;
    } t_entry;

    // one result as handed to the output register
    typedef struct packed {
        logic                hit;
        logic [ITEM_W-1:0]   item;
        logic [WEIGHT_W-1:0] weight;
        logic [CNT_W-1:0]    index;
        logic [TOTAL_W-1:0]  total;
        logic [CNT_W-1:0]    count;
    } t_result;

    // shared adder operations
    typedef enum logic [1:0] {
        ALU_ADD     = 2'd0,
        ALU_ADD_SAT = 2'd1,
        ALU_SUB_SAT = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [ACC_W-1:0]    a;
        logic [WEIGHT_W-1:0] b;
        logic [DRAW_W-1:0]   cmp;
    } t_alu_req;

    typedef struct packed {
        logic [ACC_W-1:0] res;
        logic             le;
    } t_alu_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/wrpp_alu.sv =====
// shared add/subtract unit with saturation and draw compare
`default_nettype none

module wrpp_alu (
    input  wire wrpp_pkg::t_alu_req i_req,
    output wrpp_pkg::t_alu_rsp      o_rsp
);
    import wrpp_pkg::*;

    logic [ACC_W:0]   sum_ext;
    logic [ACC_W:0]   diff_ext;
    logic [ACC_W-1:0] res;

    // one wide adder and one wide subtractor
    assign sum_ext  = (ACC_W+1)'(i_req.a) + (ACC_W+1)'(i_req.b);
    assign diff_ext = (ACC_W+1)'(i_req.a) - (ACC_W+1)'(i_req.b);

    // result select with clamping
    always_comb begin
        case (i_req.op)
            ALU_ADD: begin
                res = sum_ext[ACC_W-1:0];
            end
            ALU_ADD_SAT: begin
                if (sum_ext > (ACC_W+1)'(TOTAL_MAX)) begin
                    res = ACC_W'(TOTAL_MAX);
                end else begin
                    res = sum_ext[ACC_W-1:0];
                end
            end
            ALU_SUB_SAT: begin
                if (diff_ext[ACC_W]) begin
                    res = '0;
                end else begin
                    res = diff_ext[ACC_W-1:0];
                end
            end
            default: begin
                res = i_req.a;
            end
        endcase
    end

    // draw at or below the new running sum
    assign o_rsp.res = res;
    assign o_rsp.le  = (ACC_W'(i_req.cmp) <= res);

endmodule

`default_nettype wire

// ===== rtl/core/wrpp_ctrl.sv =====
// pool memory and command sequencer: scan, fetch, compaction and total update
`default_nettype none

module wrpp_ctrl (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    input  wire  [1:0]                    i_cmd,
    input  wire  [wrpp_pkg::ITEM_W-1:0]   i_item_id,
    input  wire  [wrpp_pkg::WEIGHT_W-1:0] i_item_weight,
    input  wire  [wrpp_pkg::DRAW_W-1:0]   i_draw_value,
    input  wire  wrpp_pkg::t_cfg          i_cfg,
    input  wire                           i_out_free,
    output logic                          o_in_ready,
    output logic                          o_res_valid,
    output wrpp_pkg::t_result             o_res,
    output wrpp_pkg::t_alu_req            o_alu_req,
    input  wire  wrpp_pkg::t_alu_rsp      i_alu_rsp
);
    import wrpp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_SHIFT,
        S_FIN,
        S_DONE
    } t_state;

    t_state              r_state,      n_state;
    t_cmd                r_cmd,        n_cmd;
    logic [ITEM_W-1:0]   r_item,       n_item;
    logic [DRAW_W-1:0]   r_draw,       n_draw;
    logic [CNT_W-1:0]    r_count,      n_count;
    logic [TOTAL_W-1:0]  r_total,      n_total;
    logic [ACC_W-1:0]    r_sum,        n_sum;
    logic [CNT_W-1:0]    r_ptr,        n_ptr;
    logic [CNT_W-1:0]    r_chk,        n_chk;
    logic                r_dv,         n_dv;
    logic [CNT_W-1:0]    r_wptr,       n_wptr;
    logic [CNT_W-1:0]    r_pos,        n_pos;
    logic [ITEM_W-1:0]   r_sel_item,   n_sel_item;
    logic [WEIGHT_W-1:0] r_sel_weight, n_sel_weight;
    logic                r_hit,        n_hit;

    // pool memory, one write and one registered read port
    t_entry              r_mem [POOL_DEPTH];
    t_entry              r_rd_data;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_wa;
    t_entry              mem_wd;
    logic [IDX_W-1:0]    mem_ra;

    logic                match;
    logic                take;
    logic                pick_hit;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // scan hit test: item compare for remove, running sum compare for pick
    always_comb begin
        if (r_cmd == CMD_REMOVE) begin
            match = (r_rd_data.item == r_item);
        end else begin
            match = (r_rd_data.weight != '0) && i_alu_rsp.le;
        end
    end

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_item       = r_item;
        n_draw       = r_draw;
        n_count      = r_count;
        n_total      = r_total;
        n_sum        = r_sum;
        n_ptr        = r_ptr;
        n_chk        = r_chk;
        n_dv         = r_dv;
        n_wptr       = r_wptr;
        n_pos        = r_pos;
        n_sel_item   = r_sel_item;
        n_sel_weight = r_sel_weight;
        n_hit        = r_hit;
        mem_we       = 1'b0;
        mem_wa       = r_wptr[IDX_W-1:0];
        mem_wd       = r_rd_data;
        mem_ra       = r_ptr[IDX_W-1:0];
        take         = 1'b0;
        o_alu_req    = '{op: ALU_ADD, a: r_sum, b: r_rd_data.weight, cmp: r_draw};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_item  = i_item_id;
                    n_draw  = i_draw_value;
                    n_hit   = 1'b0;
                    n_pos   = r_count;
                    n_sum   = '0;
                    n_ptr   = '0;
                    n_chk   = '0;
                    n_dv    = 1'b0;
                    n_state = S_DONE;
                    case (t_cmd'(i_cmd))
                        CMD_ADD: begin
                            if (i_item_weight != '0 && r_count < CNT_W'(POOL_DEPTH)) begin
                                mem_we    = 1'b1;
                                mem_wa    = r_count[IDX_W-1:0];
                                mem_wd    = '{item: i_item_id, weight: i_item_weight};
                                n_count   = r_count + 1'b1;
                                o_alu_req = '{op: ALU_ADD_SAT, a: ACC_W'(r_total),
                                              b: i_item_weight, cmp: i_draw_value};
                                n_total   = TOTAL_W'(i_alu_rsp.res);
                                n_hit     = 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_PICK: begin
                            if (r_count != '0 && r_total != '0) begin
                                if (i_cfg.uniform_mode) begin
                                    if (i_draw_value < DRAW_W'(r_count)) begin
                                        mem_ra  = i_draw_value[IDX_W-1:0];
                                        n_pos   = CNT_W'(i_draw_value);
                                        n_state = S_FETCH;
                                    end
                                end else begin
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_total = '0;
                            n_hit   = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // one entry read per cycle, tested in the cycle after its read
            S_SCAN: begin
                if (r_ptr < r_count) begin
                    n_ptr = r_ptr + 1'b1;
                    n_dv  = 1'b1;
                end else begin
                    n_dv  = 1'b0;
                end
                if (r_dv) begin
                    if (match) begin
                        n_pos = r_chk;
                        take  = 1'b1;
                    end else begin
                        n_sum = i_alu_rsp.res;
                        n_chk = r_chk + 1'b1;
                        if (r_chk == r_count - 1'b1) begin
                            n_state = S_DONE;
                        end
                    end
                end
            end

            // uniform pick: entry data arrives from the read issued on accept
            S_FETCH: begin
                take = 1'b1;
            end

            // move each later entry down by one
            S_SHIFT: begin
                if (r_ptr < r_count) begin
                    n_ptr = r_ptr + 1'b1;
                    n_dv  = 1'b1;
                end else begin
                    n_dv  = 1'b0;
                end
                if (r_dv) begin
                    mem_we = 1'b1;
                    mem_wa = r_wptr[IDX_W-1:0];
                    mem_wd = r_rd_data;
                    n_wptr = r_wptr + 1'b1;
                end
                if (!(r_ptr < r_count) && !r_dv) begin
                    n_state = S_FIN;
                end
            end

            // drop the entry from count and total
            S_FIN: begin
                o_alu_req = '{op: ALU_SUB_SAT, a: ACC_W'(r_total), b: r_sel_weight,
                              cmp: r_draw};
                n_total   = TOTAL_W'(i_alu_rsp.res);
                n_count   = r_count - 1'b1;
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // selected entry: latch it and start compaction if it leaves the pool
        if (take) begin
            n_sel_item   = r_rd_data.item;
            n_sel_weight = r_rd_data.weight;
            n_hit        = 1'b1;
            if (r_cmd == CMD_REMOVE || i_cfg.remove_on_pick) begin
                n_ptr   = n_pos + 1'b1;
                n_wptr  = n_pos;
                n_dv    = 1'b0;
                n_state = S_SHIFT;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    // state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_dv    <= n_dv;
        end
        r_cmd        <= n_cmd;
        r_item       <= n_item;
        r_draw       <= n_draw;
        r_sum        <= n_sum;
        r_ptr        <= n_ptr;
        r_chk        <= n_chk;
        r_wptr       <= n_wptr;
        r_pos        <= n_pos;
        r_sel_item   <= n_sel_item;
        r_sel_weight <= n_sel_weight;
        r_hit        <= n_hit;
    end

    // result assembly
    assign pick_hit    = (r_cmd == CMD_PICK) && r_hit;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.hit    = r_hit;
        o_res.item   = pick_hit ? r_sel_item : '0;
        o_res.weight = pick_hit ? r_sel_weight : '0;
        o_res.index  = (r_cmd == CMD_PICK) ? r_pos : '0;
        o_res.total  = r_total;
        o_res.count  = r_count;
    end

    // checks
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(POOL_DEPTH))
        else $error("pool count beyond depth");

    a_shift_write_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_dv) |-> (r_wptr + 1'b1 < r_count))
        else $error("compaction write outside live entries");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_cmd == CMD_CLEAR)
        |=> (r_count == '0 && r_total == '0))
        else $error("clear left entries behind");

    a_erase_drops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_count == $past(r_count) - 1'b1))
        else $error("erase did not drop exactly one entry");

endmodule

`default_nettype wire

// ===== rtl/core/weighted_random_pick_pool_core.sv =====
// top level: configuration registers, output register and the sequencer with its adder
// add, clear and requests refused on arrival go straight to the result, a uniform pick
// first reads its entry; remove and weighted pick test one entry per cycle up to a hit or
// the end of the pool; an erase moves each later entry down by one, then takes the entry
// off the total and count; one request at a time, the next is taken in the cycle after
// the result is loaded; reset empties the pool
`default_nettype none

module weighted_random_pick_pool_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire  [1:0]                      i_command,
    input  wire  [wrpp_pkg::ITEM_W-1:0]     i_item_id,
    input  wire  [wrpp_pkg::WEIGHT_W-1:0]   i_item_weight,
    input  wire  [wrpp_pkg::DRAW_W-1:0]     i_draw_value,
    input  wire                             i_cfg_we,
    input  wire  [wrpp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [wrpp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic                            o_hit,
    output logic [wrpp_pkg::ITEM_W-1:0]     o_picked_item,
    output logic [wrpp_pkg::WEIGHT_W-1:0]   o_picked_weight,
    output logic [wrpp_pkg::CNT_W-1:0]      o_picked_index,
    output logic [wrpp_pkg::TOTAL_W-1:0]    o_pool_total,
    output logic [wrpp_pkg::CNT_W-1:0]      o_pool_count
);
    import wrpp_pkg::*;

    t_cfg     r_cfg;
    t_result  r_out;
    logic     r_out_valid;
    logic     in_ready;
    logic     res_valid;
    t_result  res;
    logic     out_free;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REMOVE_ON_PICK: r_cfg.remove_on_pick <= i_cfg_data[0];
                CFG_UNIFORM_MODE:   r_cfg.uniform_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // sequencer with pool memory
    wrpp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_cmd         (i_command),
        .i_item_id     (i_item_id),
        .i_item_weight (i_item_weight),
        .i_draw_value  (i_draw_value),
        .i_cfg         (r_cfg),
        .i_out_free    (out_free),
        .o_in_ready    (in_ready),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_alu_req     (alu_req),
        .i_alu_rsp     (alu_rsp)
    );

    // shared adder
    wrpp_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign o_in_stall = !in_ready;
    assign out_free   = !r_out_valid || !i_out_stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out.hit;
    assign o_picked_item   = r_out.item;
    assign o_picked_weight = r_out.weight;
    assign o_picked_index  = r_out.index;
    assign o_pool_total    = r_out.total;
    assign o_pool_count    = r_out.count;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench for the weighted random pick pool core
`timescale 1ns / 1ps

module tb;
    import wrpp_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int LIMIT_CYCLES   = 4_000_000;
    localparam int HOLD_CYCLES    = 300;
    localparam int NUM_PHASES     = 8;
    localparam int RAND_PER_PHASE = 110;
    localparam int DRAIN_LIMIT    = 50_000;
    localparam int SETTLE_CYCLES  = 2 * POOL_DEPTH + 8;
    localparam int MAX_REPORTS    = 20;

    typedef enum {ROW_REQUEST, ROW_REGISTER} t_row_kind;

    // one line of the directed table
    typedef struct {
        t_row_kind                kind;
        t_cmd                     cmd;
        logic [ITEM_W-1:0]        item;
        logic [WEIGHT_W-1:0]      weight;
        logic [DRAW_W-1:0]        draw;
        bit                       typed;
        t_result                  want;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic                     reg_val;
    } t_dir_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_command     = 2'b00;
    logic [ITEM_W-1:0]     i_item_id     = '0;
    logic [WEIGHT_W-1:0]   i_item_weight = '0;
    logic [DRAW_W-1:0]     i_draw_value  = '0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic                  o_hit;
    logic [ITEM_W-1:0]     o_picked_item;
    logic [WEIGHT_W-1:0]   o_picked_weight;
    logic [CNT_W-1:0]      o_picked_index;
    logic [TOTAL_W-1:0]    o_pool_total;
    logic [CNT_W-1:0]      o_pool_count;

    // mirror of the pool and its registers
    logic [ITEM_W-1:0]   pool_item   [POOL_DEPTH];
    logic [WEIGHT_W-1:0] pool_weight [POOL_DEPTH];
    int                  pool_len    = 0;
    int                  pool_sum    = 0;
    bit                  cfg_erase   = 1'b0;
    bit                  cfg_uniform = 1'b0;

    t_result     pending_results[$];
    t_dir_row    dir_rows[$];
    int          pool_cap       = 16;
    int          send_idle_pct  = 0;
    int          stall_pct      = 0;
    int unsigned hold_ask       = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;
    int unsigned cycle_count    = 0;
    int          n_errors       = 0;
    int          n_sent         = 0;
    int          n_directed     = 0;
    int          n_checked      = 0;
    int          n_pick_hits    = 0;

    weighted_random_pick_pool_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_item_id       (i_item_id),
        .i_item_weight   (i_item_weight),
        .i_draw_value    (i_draw_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_picked_item   (o_picked_item),
        .o_picked_weight (o_picked_weight),
        .o_picked_index  (o_picked_index),
        .o_pool_total    (o_pool_total),
        .o_pool_count    (o_pool_count)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: run limit reached, %0d results still due", $time,
                     pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // drop an entry, close the gap and take its weight off the total
    function automatic void pool_erase(int pos);
        int w;
        w = int'(pool_weight[pos]);
        for (int k = pos; k + 1 < pool_len; k++) begin
            pool_item[k]   = pool_item[k + 1];
            pool_weight[k] = pool_weight[k + 1];
        end
        pool_len--;
        pool_sum = (pool_sum >= w) ? pool_sum - w : 0;
    endfunction

    // apply one request to the mirror and return the result it gives
    function automatic t_result pool_apply(t_cmd c, logic [ITEM_W-1:0] id,
                                           logic [WEIGHT_W-1:0] w, logic [DRAW_W-1:0] d);
        t_result r;
        int      pos;
        int      run;
        bit      found;
        r     = '0;
        found = 1'b0;
        pos   = pool_len;
        case (c)
            CMD_ADD: begin
                if (w != 0 && pool_len < POOL_DEPTH) begin
                    pool_item[pool_len]   = id;
                    pool_weight[pool_len] = w;
                    pool_len++;
                    pool_sum += int'(w);
                    if (pool_sum > int'(TOTAL_MAX))
                        pool_sum = int'(TOTAL_MAX);
                    r.hit = 1'b1;
                end
            end
            CMD_REMOVE: begin
                for (int k = 0; k < pool_len && !found; k++)
                    if (pool_item[k] == id) begin
                        found = 1'b1;
                        pos   = k;
                    end
                if (found) begin
                    pool_erase(pos);
                    r.hit = 1'b1;
                end
            end
            CMD_PICK: begin
                if (pool_len != 0 && pool_sum != 0) begin
                    if (cfg_uniform) begin
                        if (d < pool_len) begin
                            pos   = int'(d);
                            found = 1'b1;
                        end
                    end else begin
                        run = 0;
                        for (int k = 0; k < pool_len && !found; k++)
                            if (pool_weight[k] != 0) begin
                                run += int'(pool_weight[k]);
                                if (d <= run) begin
                                    pos   = k;
                                    found = 1'b1;
                                end
                            end
                    end
                end
                if (found) begin
                    r.hit    = 1'b1;
                    r.item   = pool_item[pos];
                    r.weight = pool_weight[pos];
                    r.index  = CNT_W'(pos);
                    if (cfg_erase)
                        pool_erase(pos);
                end else begin
                    r.index = CNT_W'(pool_len);
                end
            end
            default: begin
                pool_len = 0;
                pool_sum = 0;
                r.hit    = 1'b1;
            end
        endcase
        r.total = TOTAL_W'(pool_sum);
        r.count = CNT_W'(pool_len);
        return r;
    endfunction

    function automatic t_result mk_result(bit h, int item, int weight, int index,
                                          int total, int count);
        t_result r;
        r.hit    = h;
        r.item   = ITEM_W'(item);
        r.weight = WEIGHT_W'(weight);
        r.index  = CNT_W'(index);
        r.total  = TOTAL_W'(total);
        r.count  = CNT_W'(count);
        return r;
    endfunction

    function automatic t_dir_row known_row(t_cmd c, int id, int w, int d, t_result want);
        t_dir_row row;
        row.kind    = ROW_REQUEST;
        row.cmd     = c;
        row.item    = ITEM_W'(id);
        row.weight  = WEIGHT_W'(w);
        row.draw    = DRAW_W'(d);
        row.typed   = 1'b1;
        row.want    = want;
        row.reg_idx = '0;
        row.reg_val = 1'b0;
        return row;
    endfunction

    function automatic t_dir_row req_row(t_cmd c, int id, int w, int d);
        t_dir_row row;
        row       = known_row(c, id, w, d, '0);
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic t_dir_row reg_row(logic [CFG_IDX_W-1:0] idx, logic val);
        t_dir_row row;
        row         = req_row(CMD_CLEAR, 0, 0, 0);
        row.kind    = ROW_REGISTER;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // append one line to the directed table
    function automatic void add_row(t_dir_row row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // present one request, wait for it to be taken, then record what it should give
    task automatic issue_request(input t_cmd c, input logic [ITEM_W-1:0] id,
                                 input logic [WEIGHT_W-1:0] w, input logic [DRAW_W-1:0] d,
                                 input bit typed, input t_result want);
        int      gap;
        t_result res;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= c;
        i_item_id     <= id;
        i_item_weight <= w;
        i_draw_value  <= d;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        res = pool_apply(c, id, w, d);
        pending_results.insert(pending_results.size(), typed ? want : res);
        n_sent++;
        if (c == CMD_PICK && res.hit)
            n_pick_hits++;
    endtask

    // let every result drain before touching the registers
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_REMOVE_ON_PICK)
            cfg_erase = val;
        else if (idx == CFG_UNIFORM_MODE)
            cfg_uniform = val;
        @(posedge i_clk);
    endtask

    // random request shaped by what the pool holds right now
    task automatic random_request();
        int                  r;
        int                  k;
        int                  run;
        t_cmd                c;
        logic [ITEM_W-1:0]   id;
        logic [WEIGHT_W-1:0] w;
        logic [DRAW_W-1:0]   d;
        r = $urandom_range(0, 99);
        if (r < 3)
            c = CMD_CLEAR;
        else if (r < 48)
            c = (pool_len >= pool_cap) ? CMD_PICK : CMD_ADD;
        else if (r < 65)
            c = CMD_REMOVE;
        else
            c = CMD_PICK;
        // fields the command does not use carry noise
        id = ITEM_W'($urandom);
        w  = WEIGHT_W'($urandom);
        d  = DRAW_W'($urandom);
        r  = $urandom_range(0, 99);
        case (c)
            CMD_ADD: begin
                if ($urandom_range(0, 1) == 0)
                    id = ITEM_W'($urandom_range(0, 15));
                if (r < 6)
                    w = '0;
                else if (r < 36)
                    w = WEIGHT_W'($urandom_range(1, 16));
                else if (r < 43)
                    w = '1;
                else if (w == 0)
                    w = 16'd1;
            end
            CMD_REMOVE: begin
                if (pool_len != 0 && r < 70)
                    id = pool_item[$urandom_range(0, pool_len - 1)];
                else if (r < 85)
                    id = ITEM_W'($urandom_range(0, 15));
            end
            CMD_PICK: begin
                if (cfg_uniform) begin
                    if (r < 70 && pool_len != 0)
                        d = DRAW_W'($urandom_range(0, pool_len - 1));
                    else if (r < 85)
                        d = DRAW_W'(pool_len);
                end else if (r < 50) begin
                    d = DRAW_W'($urandom_range(0, pool_sum));
                end else if (r < 75 && pool_len != 0) begin
                    // land on, just under or just past a running sum
                    k   = $urandom_range(0, pool_len - 1);
                    run = 0;
                    for (int j = 0; j <= k; j++)
                        run += int'(pool_weight[j]);
                    d = DRAW_W'(run + $urandom_range(0, 2) - 1);
                end else if (r < 90) begin
                    d = DRAW_W'(pool_sum + $urandom_range(1, 3));
                end
            end
            default: ;
        endcase
        issue_request(c, id, w, d, 1'b0, '0);
    endtask

    // receiver: random stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_seen   <= 0;
            hold_left   <= 0;
        end else if (hold_seen != hold_ask) begin
            hold_seen   <= hold_ask;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic note_field(input string name, input logic [TOTAL_W-1:0] want_v,
                              input logic [TOTAL_W-1:0] got_v);
        if (got_v !== want_v)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    endtask

    // compare each delivered result with the oldest one due
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_hit, o_picked_item, o_picked_weight, o_picked_index,
                   o_pool_total, o_pool_count};
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: result with none due, expected nothing, got item %0d",
                             $time, o_picked_item);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        note_field("hit", TOTAL_W'(want.hit), TOTAL_W'(got.hit));
                        note_field("picked_item", TOTAL_W'(want.item), TOTAL_W'(got.item));
                        note_field("picked_weight", TOTAL_W'(want.weight),
                                   TOTAL_W'(got.weight));
                        note_field("picked_index", TOTAL_W'(want.index),
                                   TOTAL_W'(got.index));
                        note_field("pool_total", want.total, got.total);
                        note_field("pool_count", TOTAL_W'(want.count), TOTAL_W'(got.count));
                    end
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_dir_row row;
        int       waited;

        // pool starts empty
        add_row(known_row(CMD_PICK, 0, 0, 0, mk_result(0, 0, 0, 0, 0, 0)));
        add_row(known_row(CMD_REMOVE, 5, 0, 0, mk_result(0, 0, 0, 0, 0, 0)));
        // zero weight is turned away
        add_row(known_row(CMD_ADD, 16'hFFFF, 0, 24'hFFFFFF, mk_result(0, 0, 0, 0, 0, 0)));
        add_row(known_row(CMD_ADD, 0, 1, 0, mk_result(1, 0, 0, 0, 1, 1)));
        add_row(known_row(CMD_ADD, 16'hFFFF, 16'hFFFF, 0, mk_result(1, 0, 0, 0, 65536, 2)));
        add_row(known_row(CMD_ADD, 16'h1234, 100, 0, mk_result(1, 0, 0, 0, 65636, 3)));
        // same item twice
        add_row(known_row(CMD_ADD, 0, 7, 0, mk_result(1, 0, 0, 0, 65643, 4)));
        // weighted picks: zero draw, inside, exact sums, past the end
        add_row(req_row(CMD_PICK, 16'hFFFF, 16'hFFFF, 0));
        add_row(req_row(CMD_PICK, 0, 0, 2));
        add_row(req_row(CMD_PICK, 0, 0, 65636));
        add_row(req_row(CMD_PICK, 0, 0, 65643));
        add_row(req_row(CMD_PICK, 0, 0, 24'hFFFFFF));
        // only the first matching item goes, unknown item is a miss
        add_row(req_row(CMD_REMOVE, 0, 0, 0));
        add_row(req_row(CMD_REMOVE, 16'h4321, 0, 0));
        add_row(reg_row(CFG_UNIFORM_MODE, 1'b1));
        add_row(req_row(CMD_PICK, 0, 0, 0));
        add_row(req_row(CMD_PICK, 0, 0, 2));
        add_row(req_row(CMD_PICK, 0, 0, 3));
        add_row(reg_row(CFG_REMOVE_ON_PICK, 1'b1));
        add_row(req_row(CMD_PICK, 0, 0, 1));
        add_row(reg_row(CFG_UNIFORM_MODE, 1'b0));
        add_row(req_row(CMD_PICK, 0, 0, 65535));
        add_row(req_row(CMD_PICK, 0, 0, 8));
        add_row(req_row(CMD_PICK, 0, 0, 7));
        add_row(known_row(CMD_PICK, 0, 0, 0, mk_result(0, 0, 0, 0, 0, 0)));
        add_row(known_row(CMD_ADD, 16'hA5A5, 5, 0, mk_result(1, 0, 0, 0, 5, 1)));
        add_row(known_row(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                          mk_result(1, 0, 0, 0, 0, 0)));
        add_row(reg_row(CFG_REMOVE_ON_PICK, 1'b0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_REGISTER) begin
                wait_idle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                issue_request(row.cmd, row.item, row.weight, row.draw, row.typed, row.want);
                n_directed++;
            end
        end

        // random phases: register setting and pacing change together
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_reg(CFG_REMOVE_ON_PICK, p >= 4);
            write_reg(CFG_UNIFORM_MODE, 1'((p / 2) % 2));
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 75; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 75; end
                default: begin send_idle_pct = 22; stall_pct <= 22; end
            endcase
            pool_cap = $urandom_range(4, 40);
            // long receiver hold-off while requests keep coming
            if (p == 0)
                hold_ask <= hold_ask + 1;
            if (p == 1 || p == 6) begin
                // fill the pool to the brim with heavy entries
                pool_cap = POOL_DEPTH;
                issue_request(CMD_CLEAR, ITEM_W'($urandom), WEIGHT_W'($urandom),
                              DRAW_W'($urandom), 1'b0, '0);
                repeat (POOL_DEPTH)
                    issue_request(CMD_ADD, ITEM_W'($urandom),
                                  WEIGHT_W'($urandom_range(32768, 65535)),
                                  DRAW_W'($urandom), 1'b0, '0);
                issue_request(CMD_ADD, ITEM_W'($urandom), 16'hFFFF, DRAW_W'($urandom),
                              1'b0, '0);
                issue_request(CMD_PICK, ITEM_W'($urandom), WEIGHT_W'($urandom),
                              DRAW_W'(cfg_uniform ? POOL_DEPTH : pool_sum + 1), 1'b0, '0);
                repeat (12) random_request();
                issue_request(CMD_CLEAR, ITEM_W'($urandom), WEIGHT_W'($urandom),
                              DRAW_W'($urandom), 1'b0, '0);
                pool_cap = $urandom_range(4, 40);
            end
            repeat (RAND_PER_PHASE) random_request();
        end

        // drain and settle
        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            n_errors++;
            $display("%0t: %0d results never arrived, expected 0 left, got %0d", $time,
                     pending_results.size(), pending_results.size());
        end

        $display("covered %0d requests (%0d from the table) over %0d pacing and mode phases,",
                 n_sent, n_directed, NUM_PHASES);
        $display("two full-pool passes; %0d results checked, %0d pick hits, %0d bad results",
                 n_checked, n_pick_hits, n_errors);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
